// ----- sv/atan2cq_pkg.sv -----
// ----------------------------------------------------------------------------
// atan2cq_pkg: shared types and constants of the cubic atan2 block
// Sample and angle formats, polynomial coefficients, octant bases and
// the side-band record carried along the divider pipeline.
// ----------------------------------------------------------------------------
package atan2cq_pkg;

	localparam int SampleWidth   = 16;
	localparam int AngleWidth    = 16;
	localparam int AngleFracBits = 13;

	// ratio r is Q1.15, one quotient bit per divider step
	localparam int RatioWidth = 16;
	localparam int DivSteps   = RatioWidth;

	localparam int AbsWidth = SampleWidth + 1;
	localparam int DenWidth = SampleWidth + 1;
	localparam int SumWidth = SampleWidth + 2;
	localparam int RemWidth = SampleWidth + 2;

	localparam int MagWidth   = 34;
	localparam int RoundShift = 30 - AngleFracBits;

	localparam logic [RatioWidth-1:0]      CoefC3 = RatioWidth'(6432);   // 0.1963 in Q.15
	localparam logic signed [16:0]         CoefC1 = 17'sd32168;          // 0.9817 in Q.15
	localparam logic signed [MagWidth-1:0] BaseQtr  = 34'sd843314857;   // pi/4 in Q.30
	localparam logic signed [MagWidth-1:0] Base3Qtr = 34'sd2529944570;  // 3*pi/4 in Q.30
	localparam logic [MagWidth-1:0]        RoundHalf = MagWidth'(1) << (RoundShift - 1);

	localparam logic signed [RatioWidth-1:0] RatioMax = {1'b0, {(RatioWidth-1){1'b1}}};
	localparam logic signed [RatioWidth-1:0] RatioMin = {1'b1, {(RatioWidth-1){1'b0}}};
	localparam logic signed [AngleWidth-1:0] AngleMax = {1'b0, {(AngleWidth-1){1'b1}}};
	localparam logic signed [AngleWidth-1:0] AngleMin = {1'b1, {(AngleWidth-1){1'b0}}};

	typedef struct packed {
		logic y_neg;     // result gets negated
		logic x_neg;     // 3*pi/4 base instead of pi/4
		logic num_neg;   // sign of the ratio
		logic den_zero;  // origin: ratio forced to -1
	} side_t;

endpackage

// ----- sv/atan2_cubic_quadrant.sv -----
// ----------------------------------------------------------------------------
// atan2_cubic_quadrant: pipelined fast atan2 with a cubic correction
// Forms the octant ratio by a bit-per-stage divider, then evaluates
// base + (0.1963*r^2 - 0.9817)*r and applies the sign of y.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: y_in/x_in are taken at each rising edge where start is
//   high and busy is low. busy is held low, so a new item can enter on
//   every cycle.
//   Result channel: angle_out (Q3.13 radians) is valid for exactly one
//   cycle while done is high. The receiver cannot hold results off, and the
//   pipeline never needs to stall.
//   Pipeline: 24 register stages (2 setup stages, 16 divider stages, 6 stages
//   for ratio fixup, two multiplies, final multiply, add and rounding).
//   Throughput: one item per cycle; each divider stage resolves one
//   quotient bit so every stage is free again the next cycle.
//   Reset (arst_n low) clears all valid bits; items in flight are dropped
//   and done stays low until new items come through.
// ----------------------------------------------------------------------------
module atan2_cubic_quadrant (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	output logic                                         busy,
	input  logic signed [atan2cq_pkg::SampleWidth-1:0]   y_in,
	input  logic signed [atan2cq_pkg::SampleWidth-1:0]   x_in,
	output logic                                         done,
	output logic signed [atan2cq_pkg::AngleWidth-1:0]    angle_out
);

	localparam int SW = atan2cq_pkg::SampleWidth;
	localparam int AW = atan2cq_pkg::AbsWidth;
	localparam int DW = atan2cq_pkg::DenWidth;
	localparam int UW = atan2cq_pkg::SumWidth;
	localparam int MW = atan2cq_pkg::RemWidth;
	localparam int RW = atan2cq_pkg::RatioWidth;
	localparam int NS = atan2cq_pkg::DivSteps;
	localparam int GW = atan2cq_pkg::MagWidth;
	localparam int OW = atan2cq_pkg::AngleWidth;

	// ---------------- stage 1: |y| ----------------
	logic signed [AW-1:0] y_ext;
	logic [AW-1:0]        ay_d;
	logic                 vld_s1;
	logic                 y_neg_s1;
	logic signed [SW-1:0] x_s1;
	logic [AW-1:0]        ay_s1;

	assign busy  = 1'b0;
	assign y_ext = AW'(y_in);
	assign ay_d  = y_in[SW-1] ? unsigned'(-y_ext) : unsigned'(y_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		y_neg_s1 <= y_in[SW-1];
		x_s1     <= x_in;
		ay_s1    <= ay_d;
	end

	// ---------------- stage 2: numerator and divisor ----------------
	logic signed [UW-1:0] x_w;
	logic signed [UW-1:0] ay_w;
	logic signed [UW-1:0] num_d;
	logic signed [UW-1:0] den_d;
	logic signed [UW-1:0] anum_d;
	logic                 x_neg;
	logic                 vld_s2;
	logic [AW-1:0]        anum_s2;
	logic [DW-1:0]        den_s2;
	atan2cq_pkg::side_t   side_s2;

	assign x_w    = UW'(x_s1);
	assign ay_w   = signed'(UW'(ay_s1));
	assign x_neg  = x_s1[SW-1];
	assign num_d  = x_neg ? (x_w + ay_w) : (x_w - ay_w);
	assign den_d  = x_neg ? (ay_w - x_w) : (x_w + ay_w);
	assign anum_d = num_d[UW-1] ? -num_d : num_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		anum_s2          <= anum_d[AW-1:0];
		den_s2           <= den_d[DW-1:0];
		side_s2.y_neg    <= y_neg_s1;
		side_s2.x_neg    <= x_neg;
		side_s2.num_neg  <= num_d[UW-1];
		side_s2.den_zero <= (den_d == '0);
	end

	// ---------------- stage 3: restoring divider, one bit per step ----------------
	// |num| <= den, so the quotient |num|*2^15/den never exceeds 2^15.
	logic [MW-1:0]      div_rem_s3  [NS];
	logic [DW-1:0]      div_den_s3  [NS];
	logic [RW-1:0]      div_q_s3    [NS];
	atan2cq_pkg::side_t div_side_s3 [NS];
	logic [NS-1:0]      div_vld_s3;

	logic [MW-1:0] stp_rem_in [NS];
	logic [DW-1:0] stp_den_in [NS];
	logic [RW-1:0] stp_q_in   [NS];
	logic [MW-1:0] div_rem_d  [NS];
	logic [RW-1:0] div_q_d    [NS];
	logic [NS-1:0] stp_ge;

	always_comb begin
		stp_rem_in[0] = MW'(anum_s2);
		stp_den_in[0] = den_s2;
		stp_q_in[0]   = '0;
		for (int k = 1; k < NS; k++) begin
			stp_rem_in[k] = div_rem_s3[k-1];
			stp_den_in[k] = div_den_s3[k-1];
			stp_q_in[k]   = div_q_s3[k-1];
		end
	end

	always_comb begin
		logic [MW-1:0] dif;
		dif = '0;
		for (int k = 0; k < NS; k++) begin
			stp_ge[k]    = stp_rem_in[k] >= MW'(stp_den_in[k]);
			dif          = stp_ge[k] ? (stp_rem_in[k] - MW'(stp_den_in[k])) : stp_rem_in[k];
			div_rem_d[k] = {dif[MW-2:0], 1'b0};
			div_q_d[k]   = {stp_q_in[k][RW-2:0], stp_ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s3 <= '0;
		end else begin
			div_vld_s3 <= {div_vld_s3[NS-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		div_side_s3[0] <= side_s2;
		for (int k = 0; k < NS; k++) begin
			div_rem_s3[k] <= div_rem_d[k];
			div_den_s3[k] <= stp_den_in[k];
			div_q_s3[k]   <= div_q_d[k];
		end
		for (int k = 1; k < NS; k++) begin
			div_side_s3[k] <= div_side_s3[k-1];
		end
	end

	// ---------------- stage 4: signed, saturated ratio ----------------
	logic [RW-1:0]          q_last;
	atan2cq_pkg::side_t     side_last;
	logic signed [RW-1:0]   r_d;
	logic                   vld_s4;
	logic signed [RW-1:0]   r_s4;
	logic                   y_neg_s4;
	logic                   x_neg_s4;

	assign q_last    = div_q_s3[NS-1];
	assign side_last = div_side_s3[NS-1];

	always_comb begin
		if (side_last.den_zero) begin
			r_d = atan2cq_pkg::RatioMin;
		end else if (q_last[RW-1]) begin
			// quotient reached exactly 1.0
			r_d = side_last.num_neg ? atan2cq_pkg::RatioMin : atan2cq_pkg::RatioMax;
		end else begin
			r_d = side_last.num_neg ? -signed'(q_last) : signed'(q_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= div_vld_s3[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		r_s4     <= r_d;
		y_neg_s4 <= side_last.y_neg;
		x_neg_s4 <= side_last.x_neg;
	end

	// ---------------- stage 5: r^2 ----------------
	logic signed [2*RW-1:0] rr_prod;
	logic                   vld_s5;
	logic [RW-1:0]          r2_s5;
	logic signed [RW-1:0]   r_s5;
	logic                   y_neg_s5;
	logic                   x_neg_s5;

	assign rr_prod = r_s4 * r_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		r2_s5    <= rr_prod[2*RW-2:RW-1];
		r_s5     <= r_s4;
		y_neg_s5 <= y_neg_s4;
		x_neg_s5 <= x_neg_s4;
	end

	// ---------------- stage 6: coefficient C3*r^2 - C1 ----------------
	logic [2*RW-1:0]       c3_prod;
	logic [16:0]           c3_term;
	logic                  vld_s6;
	logic signed [16:0]    coef_s6;
	logic signed [RW-1:0]  r_s6;
	logic                  y_neg_s6;
	logic                  x_neg_s6;

	assign c3_prod = atan2cq_pkg::CoefC3 * r2_s5;
	assign c3_term = c3_prod[RW+15:RW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		coef_s6  <= signed'(c3_term) - atan2cq_pkg::CoefC1;
		r_s6     <= r_s5;
		y_neg_s6 <= y_neg_s5;
		x_neg_s6 <= x_neg_s5;
	end

	// ---------------- stage 7: cubic term coef*r (Q.30) ----------------
	logic signed [RW+16:0] term_d;
	logic                  vld_s7;
	logic signed [RW+16:0] term_s7;
	logic                  y_neg_s7;
	logic                  x_neg_s7;

	assign term_d = coef_s6 * r_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		term_s7  <= term_d;
		y_neg_s7 <= y_neg_s6;
		x_neg_s7 <= x_neg_s6;
	end

	// ---------------- stage 8: base + term, floored at zero ----------------
	logic signed [GW-1:0] base_sel;
	logic signed [GW-1:0] sum_d;
	logic                 vld_s8;
	logic [GW-2:0]        mag_s8;
	logic                 y_neg_s8;

	assign base_sel = x_neg_s7 ? atan2cq_pkg::Base3Qtr : atan2cq_pkg::BaseQtr;
	assign sum_d    = base_sel + GW'(term_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		mag_s8   <= sum_d[GW-1] ? '0 : sum_d[GW-2:0];
		y_neg_s8 <= y_neg_s7;
	end

	// ---------------- stage 9: round, sign, saturate ----------------
	logic [GW-1:0]      rnd_sum;
	logic [GW-1:0]      rnd;
	logic signed [GW:0] sgn;
	logic signed [OW-1:0] angle_d;
	logic                 vld_s9;
	logic signed [OW-1:0] angle_s9;

	assign rnd_sum = GW'(mag_s8) + atan2cq_pkg::RoundHalf;
	assign rnd     = rnd_sum >> atan2cq_pkg::RoundShift;
	assign sgn     = y_neg_s8 ? -signed'({1'b0, rnd}) : signed'({1'b0, rnd});

	always_comb begin
		if (sgn > (GW+1)'(atan2cq_pkg::AngleMax)) begin
			angle_d = atan2cq_pkg::AngleMax;
		end else if (sgn < (GW+1)'(atan2cq_pkg::AngleMin)) begin
			angle_d = atan2cq_pkg::AngleMin;
		end else begin
			angle_d = signed'(sgn[OW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		angle_s9 <= angle_d;
	end

	assign done      = vld_s9;
	assign angle_out = angle_s9;

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for atan2_cubic_quadrant
// A directed table of axes, diagonals and extreme samples comes first, then
// random bursts of sample pairs. Every accepted item is scored against its table
// angle or a fixed-point model of the cubic atan2 and checked in order on done.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [atan2cq_pkg::SampleWidth-1:0] sample_t;
	typedef logic signed [atan2cq_pkg::AngleWidth-1:0]  angle_t;

	typedef struct packed {
		sample_t y;
		sample_t x;
		angle_t  angle;
	} pend_t;

	typedef struct packed {
		sample_t y;
		sample_t x;
		logic    known;
		angle_t  angle;
	} row_t;

	localparam int NumRows  = 24;
	localparam int NumItems = 1600;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    done;
	sample_t y_in;
	sample_t x_in;
	angle_t  angle_out;

	pend_t pend_angles[$];
	pend_t head;
	int    taken = 0;
	int    errors = 0;
	row_t  dir_rows [0:NumRows-1];

	atan2_cubic_quadrant dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.y_in      (y_in),
		.x_in      (x_in),
		.done      (done),
		.angle_out (angle_out)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// octant ratio in Q1.15, cubic correction in Q.30, rounded to Q3.13
	function automatic angle_t angle_of(sample_t y, sample_t x);
		longint ay, num, den, base, r, r2, coef, mag;
		ay = (y < 0) ? -longint'(y) : longint'(y);
		if (x < 0) begin
			num  = longint'(x) + ay;
			den  = ay - longint'(x);
			base = longint'(atan2cq_pkg::Base3Qtr);
		end else begin
			num  = longint'(x) - ay;
			den  = longint'(x) + ay;
			base = longint'(atan2cq_pkg::BaseQtr);
		end
		if (den == 0) begin
			r = longint'(atan2cq_pkg::RatioMin);
		end else begin
			r = (num * 32768) / den;
			if (r > longint'(atan2cq_pkg::RatioMax)) r = longint'(atan2cq_pkg::RatioMax);
			if (r < longint'(atan2cq_pkg::RatioMin)) r = longint'(atan2cq_pkg::RatioMin);
		end
		r2   = (r * r) >>> 15;
		coef = ((longint'(atan2cq_pkg::CoefC3) * r2) >>> 15) - longint'(atan2cq_pkg::CoefC1);
		mag  = base + coef * r;
		if (mag < 0) mag = 0;
		mag = (mag + (longint'(1) << (atan2cq_pkg::RoundShift - 1))) >>> atan2cq_pkg::RoundShift;
		if (y < 0) mag = -mag;
		if (mag > longint'(atan2cq_pkg::AngleMax)) mag = longint'(atan2cq_pkg::AngleMax);
		if (mag < longint'(atan2cq_pkg::AngleMin)) mag = longint'(atan2cq_pkg::AngleMin);
		return angle_t'(mag);
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 5))
			0: return sample_t'(int'($urandom_range(0, 32)) - 16);
			1: return sample_t'(32767 - int'($urandom_range(0, 3)));
			2: return sample_t'(-32768 + int'($urandom_range(0, 3)));
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic put(sample_t y, sample_t x, logic known, angle_t angle);
		int    n;
		pend_t e;
		e.y     = y;
		e.x     = x;
		e.angle = known ? angle : angle_of(y, x);
		pend_angles.push_back(e);
		start = 1'b1;
		y_in  = y;
		x_in  = x;
		n     = taken;
		do @(negedge clk); while (taken == n);
	endtask

	task automatic pause(int cycles);
		start = 1'b0;
		y_in  = sample_t'($urandom);
		x_in  = sample_t'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (start && !busy)
			taken <= taken + 1;
		if (done) begin
			if (pend_angles.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected angle %0d with no item pending", angle_out);
			end else begin
				head = pend_angles.pop_front();
				if (angle_out !== head.angle) begin
					errors++;
					if (errors <= 10)
						$display("angle mismatch y=%0d x=%0d: expected %0d, got %0d",
							head.y, head.x, head.angle, angle_out);
				end
			end
		end
	end

	initial begin
		sample_t y, x;
		int      sent, burst, mode, a;

		// y, x, known, angle
		dir_rows = '{
			'{0,      0,      1'b1, 12868},   // origin, ratio forced to -1
			'{0,      32767,  1'b1, 0},       // ratio saturates, magnitude floored
			'{0,      1,      1'b1, 0},
			'{0,      -32768, 1'b1, 25736},
			'{0,      -1,     1'b1, 25736},
			'{32767,  0,      1'b1, 12868},
			'{-32768, 0,      1'b1, -12868},
			'{-1,     0,      1'b1, -12868},
			'{32767,  32767,  1'b1, 6434},
			'{1,      1,      1'b1, 6434},
			'{-32768, -32768, 1'b1, -19302},
			'{-32768, 32767,  1'b1, -6434},   // quotient truncates to zero
			'{-1,     -32768, 1'b0, 0},
			'{1,      -32768, 1'b0, 0},
			'{32767,  -32768, 1'b0, 0},
			'{-32768, -1,     1'b0, 0},
			'{-32768, -32767, 1'b0, 0},
			'{32767,  -1,     1'b0, 0},
			'{1,      32767,  1'b0, 0},
			'{-1,     32767,  1'b0, 0},
			'{100,    -3,     1'b0, 0},
			'{-7,     20000,  1'b0, 0},
			'{12345,  -23456, 1'b0, 0},
			'{21845,  -10923, 1'b0, 0}
		};

		arst_n = 1'b0;
		start  = 1'b0;
		y_in   = '0;
		x_in   = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			put(dir_rows[i].y, dir_rows[i].x, dir_rows[i].known, dir_rows[i].angle);
			if ($urandom_range(0, 2) == 0)
				pause($urandom_range(1, 4));
		end

		sent = 0;
		while (sent < NumItems) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
			repeat (burst) begin
				y    = rand_sample();
				x    = rand_sample();
				mode = $urandom_range(0, 9);
				a    = (y < 0) ? -int'(y) : int'(y);
				case (mode)
					0: if ($urandom_range(0, 1)) y = '0; else x = '0;
					// on or near a diagonal, where the ratio is close to zero
					1: x = sample_t'(($urandom_range(0, 1) ? a : -a) + int'($urandom_range(0, 4)) - 2);
					// just off the positive x axis, where the magnitude can go negative
					2: begin
						y = sample_t'(int'($urandom_range(0, 6)) - 3);
						x = sample_t'($urandom_range(1, 32767));
					end
					default: ;
				endcase
				put(y, x, 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end

		start = 1'b0;
		while (pend_angles.size() != 0) @(negedge clk);
		repeat (32) @(negedge clk);
		if (errors == 0)
			$display("PASS atan2_cubic_quadrant");
		else
			$display("FAIL atan2_cubic_quadrant");
		$finish;
	end

	initial begin
		#1ms;
		$display("FAIL atan2_cubic_quadrant");
		$finish;
	end

endmodule

// ----- atan2_cubic_quadrant.f -----
sv/atan2cq_pkg.sv
sv/atan2_cubic_quadrant.sv
bench/tb.sv
